[hw/rtl/tsc_pkg.sv]
// Shared types and constants for the tristimulus to chromaticity block.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package tsc_pkg;

	localparam int FRAC_BITS_DEF = 16;   // input fraction bits
	localparam int NUM_W         = 36;   // numerator and divisor width
	localparam int QUO_W         = 18;   // quotient bits per lane
	localparam int DIV_STEPS     = QUO_W; // one quotient bit per stage
	localparam int LANES         = 5;
	localparam int CHK_W         = 48;   // width of the screening products

	localparam int LANE_X  = 0;
	localparam int LANE_Y  = 1;
	localparam int LANE_UP = 2;
	localparam int LANE_VP = 3;
	localparam int LANE_V  = 4;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERLOAD = 2'd1,
		ST_LOWLIGHT = 2'd2,
		ST_NOTCALC  = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [31:0] tristim_x;
		logic signed [31:0] tristim_y;
		logic signed [31:0] tristim_z;
	} reading_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] chroma_x;
		logic [15:0] chroma_y;
		logic [17:0] ucs_u_prime;
		logic [15:0] ucs_v_prime;
		logic [15:0] ucs_v_1960;
	} result_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [NUM_W-1:0] den;
		logic [1:0]       sh;
		logic [QUO_W-1:0] quo;
	} lane_t;

	typedef struct packed {
		status_t              status;
		lane_t [LANES-1:0]    lanes;
	} stage_t;

endpackage
`default_nettype wire

[hw/rtl/tristimulus_to_chromaticity.sv]
// XYZ tristimulus to xy, u'v' and 1960 v chromaticity, fully pipelined.
// Throughput one request per cycle; strobe after screen, divider steps and output register.
// Rate is set by the 18-stage divider pipeline, one quotient bit per stage in five lanes.
// busy stays low: the pipeline never stalls, since results cannot be held off.
// Reset (arst_n low) clears every valid bit at once; requests in flight are dropped.
// Depends on tsc_pkg, tsc_screen and tsc_div_step.
`default_nettype none
module tristimulus_to_chromaticity #(
	parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire tsc_pkg::reading_t reading,
	output logic                   strobe,
	output tsc_pkg::result_t       result
);
	import tsc_pkg::*;

	// Valid and data at the output of each stage: index 0 is the screen stage,
	// index k the k-th division step.
	logic   valid_v [DIV_STEPS+1];
	stage_t data_v  [DIV_STEPS+1];

	logic    strobe_q;
	result_t result_q;
	stage_t  last;

	// Never hold off a request.
	assign busy = 1'b0;

	// Screen the reading: overload, low light and the not-calculated check,
	// then load divisor S or D and the scaled numerator into each lane.
	tsc_screen #(
		.FRAC_BITS(FRAC_BITS)
	) u_screen (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (start && !busy),
		.reading (reading),
		.valid_s1(valid_v[0]),
		.data_s1 (data_v[0])
	);

	// Advance the division one quotient bit per stage.
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		tsc_div_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_in(valid_v[k]),
			.data_in (data_v[k]),
			.valid_s1(valid_v[k+1]),
			.data_s1 (data_v[k+1])
		);
	end

	assign last = data_v[DIV_STEPS];

	// Output register: drop the quotients to zero on any error status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= valid_v[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		result_q.status <= last.status;
		if (last.status == ST_OK) begin
			result_q.chroma_x    <= last.lanes[LANE_X].quo[15:0];
			result_q.chroma_y    <= last.lanes[LANE_Y].quo[15:0];
			result_q.ucs_u_prime <= last.lanes[LANE_UP].quo[17:0];
			result_q.ucs_v_prime <= last.lanes[LANE_VP].quo[15:0];
			result_q.ucs_v_1960  <= last.lanes[LANE_V].quo[15:0];
		end else begin
			result_q.chroma_x    <= '0;
			result_q.chroma_y    <= '0;
			result_q.ucs_u_prime <= '0;
			result_q.ucs_v_prime <= '0;
			result_q.ucs_v_1960  <= '0;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != ST_OK |->
			result.chroma_x == '0 && result.chroma_y == '0 && result.ucs_u_prime == '0 &&
			result.ucs_v_prime == '0 && result.ucs_v_1960 == '0)
		else $error("error result with nonzero coordinates");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(DIV_STEPS+2) strobe)
		else $error("request produced no strobe after the pipeline latency");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		valid_v[DIV_STEPS] |-> $past(valid_v[0], DIV_STEPS))
		else $error("divider output valid without a matching entry");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_v[DIV_STEPS] && last.status == ST_OK |->
			last.lanes[LANE_X].quo[17:16] == 2'b00 && last.lanes[LANE_Y].quo[17:16] == 2'b00)
		else $error("chromaticity quotient out of range");

endmodule
`default_nettype wire

[hw/rtl/tsc_screen.sv]
// Front stage: screens a reading, forms the sums and loads the divider lanes.
// Depends on tsc_pkg.
`default_nettype none
module tsc_screen #(
	parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire tsc_pkg::reading_t reading,
	output logic                  valid_s1,
	output tsc_pkg::stage_t       data_s1
);
	import tsc_pkg::*;

	localparam logic signed [CHK_W-1:0] ONE  = CHK_W'(1) <<< FRAC_BITS;
	localparam logic signed [CHK_W-1:0] HALF = CHK_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [CHK_W-1:0] HUND = CHK_W'(100);

	logic signed [CHK_W-1:0] xw, yw, zw, sw, dw;
	logic                    ovl, low, notc;
	stage_t                  nxt;

	always_comb begin
		xw = CHK_W'(reading.tristim_x);
		yw = CHK_W'(reading.tristim_y);
		zw = CHK_W'(reading.tristim_z);
		sw = xw + yw + zw;
		dw = xw + (yw <<< 4) - yw + (zw <<< 1) + zw;
		ovl  = xw < -HALF;
		low  = (xw * HUND < ONE) || (yw * HUND < ONE) || (zw * HUND < ONE);
		notc = !(sw * HUND > ONE) || !(dw * HUND > ONE);
		if (ovl) begin
			nxt.status = ST_OVERLOAD;
		end else if (low) begin
			nxt.status = ST_LOWLIGHT;
		end else if (notc) begin
			nxt.status = ST_NOTCALC;
		end else begin
			nxt.status = ST_OK;
		end
		// Numerators: x, y, 4x, 9y, 6y; each lane divides num * 2^16.
		nxt.lanes[LANE_X].rem  = NUM_W'(xw[NUM_W-1:2]);
		nxt.lanes[LANE_X].sh   = xw[1:0];
		nxt.lanes[LANE_X].den  = sw[NUM_W-1:0];
		nxt.lanes[LANE_Y].rem  = NUM_W'(yw[NUM_W-1:2]);
		nxt.lanes[LANE_Y].sh   = yw[1:0];
		nxt.lanes[LANE_Y].den  = sw[NUM_W-1:0];
		nxt.lanes[LANE_UP].rem = xw[NUM_W-1:0];
		nxt.lanes[LANE_UP].sh  = 2'b00;
		nxt.lanes[LANE_UP].den = dw[NUM_W-1:0];
		// 9y and y agree in their two low bits.
		nxt.lanes[LANE_VP].rem = NUM_W'(((yw <<< 3) + yw) >>> 2);
		nxt.lanes[LANE_VP].sh  = yw[1:0];
		nxt.lanes[LANE_VP].den = dw[NUM_W-1:0];
		nxt.lanes[LANE_V].rem  = NUM_W'(((yw <<< 2) + (yw <<< 1)) >>> 2);
		nxt.lanes[LANE_V].sh   = {yw[0], 1'b0};
		nxt.lanes[LANE_V].den  = dw[NUM_W-1:0];
		for (int i = 0; i < LANES; i++) begin
			nxt.lanes[i].quo = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

endmodule
`default_nettype wire

[hw/rtl/tsc_div_step.sv]
// One restoring division step for all lanes, one quotient bit each, registered.
// Depends on tsc_pkg.
`default_nettype none
module tsc_div_step (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_in,
	input  wire tsc_pkg::stage_t data_in,
	output logic                 valid_s1,
	output tsc_pkg::stage_t      data_s1
);
	import tsc_pkg::*;

	stage_t           nxt;
	logic [NUM_W:0]   trial;
	logic [NUM_W:0]   diff;

	always_comb begin
		nxt.status = data_in.status;
		trial = '0;
		diff  = '0;
		for (int i = 0; i < LANES; i++) begin
			trial = {data_in.lanes[i].rem, data_in.lanes[i].sh[1]};
			diff  = trial - {1'b0, data_in.lanes[i].den};
			nxt.lanes[i].den = data_in.lanes[i].den;
			nxt.lanes[i].sh  = {data_in.lanes[i].sh[0], 1'b0};
			if (trial >= {1'b0, data_in.lanes[i].den}) begin
				nxt.lanes[i].rem = diff[NUM_W-1:0];
				nxt.lanes[i].quo = {data_in.lanes[i].quo[QUO_W-2:0], 1'b1};
			end else begin
				nxt.lanes[i].rem = trial[NUM_W-1:0];
				nxt.lanes[i].quo = {data_in.lanes[i].quo[QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

endmodule
`default_nettype wire
